/* design/dttb_pkg.sv */
// Package for the depth tested tile blit: sizes, field widths and the queue word.
// Used by every module of the block; depends on nothing.
package dttb_pkg;

    localparam int FB_PIXELS   = 262144;
    localparam int FB_ADDR_W   = $clog2(FB_PIXELS);
    localparam int COORD_W     = 12;
    localparam int TILE_W      = 9;
    localparam int WIDTH_W     = 13;
    localparam int DEPTH_W     = 12;
    localparam int PIXEL_W     = 32;
    localparam int ROWSUM_W    = 13;
    localparam int PROD_W      = ROWSUM_W + WIDTH_W;
    localparam int ADDR_SUM_W  = PROD_W + 1;
    localparam int S_DATA_W    = 80;
    localparam int M_DATA_W    = 40;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(512);
    localparam logic               OP_BLIT     = 1'b0;
    localparam logic               OP_READ     = 1'b1;

    typedef struct packed {
        logic                 op;
        logic                 oor;
        logic [FB_ADDR_W-1:0] addr;
        logic [DEPTH_W-1:0]   depth;
        logic [PIXEL_W-1:0]   pixel;
    } dttb_item_t;

    typedef struct packed {
        logic clearing;
    } dttb_back_status_t;

    function automatic logic [PIXEL_W-1:0] swap_red_blue(input logic [PIXEL_W-1:0] p);
        swap_red_blue = {p[31:24], p[7:0], p[15:8], p[23:16]};
    endfunction

endpackage

/* design/dttb_front.sv */
// Front end: takes input words, holds the frame width, forms the store address.
// Depends on dttb_pkg; feeds dttb_queue.
module dttb_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [dttb_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                        s_tuser,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dttb_pkg::WIDTH_W-1:0] cfg_data,
    input  dttb_pkg::dttb_back_status_t back_status,
    input  logic                        q_full,
    output logic                        q_push,
    output dttb_pkg::dttb_item_t        q_item
);
    import dttb_pkg::*;

    logic [WIDTH_W-1:0]  width_reg, width_next;
    logic                a_valid_reg, a_valid_next;
    logic                b_valid_reg, b_valid_next;
    logic                a_op_reg, b_op_reg;
    logic [COORD_W-1:0]  a_ox_reg, a_oy_reg, b_ox_reg, b_oy_reg;
    logic [TILE_W-1:0]   a_col_reg, a_row_reg, b_col_reg;
    logic [PIXEL_W-1:0]  a_pix_reg, b_pix_reg;
    logic [PROD_W-1:0]   b_prod_reg, b_prod_next;
    logic [ROWSUM_W-1:0] row_sum;
    logic [ADDR_SUM_W-1:0] addr_sum;
    logic                advance;

    assign cfg_ready = 1'b1;
    assign advance   = !b_valid_reg || !q_full;
    assign s_tready  = advance && !back_status.clearing;

    always_comb begin
        width_next = width_reg;
        if (cfg_valid) begin
            width_next = cfg_data;
        end
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        if (advance) begin
            a_valid_next = s_tvalid && s_tready;
            b_valid_next = a_valid_reg;
        end
    end

    assign row_sum     = ROWSUM_W'(a_oy_reg) + ROWSUM_W'(a_row_reg);
    assign b_prod_next = PROD_W'(row_sum) * PROD_W'(width_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WIDTH_RESET;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            width_reg   <= width_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_op_reg   <= s_tuser;
            a_ox_reg   <= s_tdata[11:0];
            a_oy_reg   <= s_tdata[23:12];
            a_col_reg  <= s_tdata[32:24];
            a_row_reg  <= s_tdata[41:33];
            a_pix_reg  <= s_tdata[73:42];
            b_op_reg   <= a_op_reg;
            b_ox_reg   <= a_ox_reg;
            b_oy_reg   <= a_oy_reg;
            b_col_reg  <= a_col_reg;
            b_pix_reg  <= a_pix_reg;
            b_prod_reg <= b_prod_next;
        end
    end

    assign addr_sum = ADDR_SUM_W'(b_prod_reg) + ADDR_SUM_W'(b_ox_reg) + ADDR_SUM_W'(b_col_reg);

    always_comb begin
        q_push       = b_valid_reg && !q_full;
        q_item.op    = b_op_reg;
        q_item.oor   = addr_sum >= ADDR_SUM_W'(FB_PIXELS);
        q_item.addr  = addr_sum[FB_ADDR_W-1:0];
        q_item.depth = b_oy_reg;
        q_item.pixel = swap_red_blue(b_pix_reg);
    end

endmodule

/* design/dttb_queue.sv */
// Short queue between front and back end, holding classified items.
// Depends on dttb_pkg.
module dttb_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  dttb_pkg::dttb_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output dttb_pkg::dttb_item_t head_item,
    output logic                 empty
);
    import dttb_pkg::*;

    dttb_item_t         slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty     = count_reg == '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* design/dttb_back.sv */
// Back end: clears the stores after reset, then reads, depth tests and writes.
// Depends on dttb_pkg; holds the frame and depth memories and the output register.
module dttb_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  dttb_pkg::dttb_item_t        head_item,
    input  logic                        q_empty,
    output logic                        q_pop,
    output dttb_pkg::dttb_back_status_t status,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [dttb_pkg::M_DATA_W-1:0] m_tdata
);
    import dttb_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_EVAL  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [FB_ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    dttb_item_t           item_reg;
    logic [PIXEL_W-1:0]   frame_mem [FB_PIXELS];
    logic [DEPTH_W-1:0]   depth_mem [FB_PIXELS];
    logic [PIXEL_W-1:0]   rd_frame_reg;
    logic [DEPTH_W-1:0]   rd_depth_reg;
    logic                 mem_we;
    logic [FB_ADDR_W-1:0] mem_addr;
    logic [PIXEL_W-1:0]   mem_wframe;
    logic [DEPTH_W-1:0]   mem_wdepth;
    logic                 out_free, do_write;
    logic                 m_valid_reg, m_valid_next;
    logic                 written_reg, oor_reg;
    logic [PIXEL_W-1:0]   pix_out_reg;

    assign out_free        = !m_valid_reg || m_tready;
    assign q_pop           = (state_reg == ST_IDLE) && !q_empty;
    assign status.clearing = state_reg == ST_CLEAR;
    assign do_write = item_reg.op == OP_BLIT && !item_reg.oor
                      && item_reg.pixel[31:24] != 8'd0 && rd_depth_reg <= item_reg.depth;

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        mem_we        = 1'b0;
        mem_addr      = item_reg.addr;
        mem_wframe    = item_reg.pixel;
        mem_wdepth    = item_reg.depth;
        case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_addr      = clr_addr_reg;
                mem_wframe    = '0;
                mem_wdepth    = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == FB_ADDR_W'(FB_PIXELS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!q_empty) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (out_free) begin
                    mem_we       = do_write;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= head_item;
        end
        if (state_reg == ST_EVAL && out_free) begin
            written_reg <= do_write;
            oor_reg     <= item_reg.oor;
            pix_out_reg <= (item_reg.op == OP_READ && !item_reg.oor) ? rd_frame_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[mem_addr] <= mem_wframe;
            depth_mem[mem_addr] <= mem_wdepth;
        end
        rd_frame_reg <= frame_mem[mem_addr];
        rd_depth_reg <= depth_mem[mem_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, pix_out_reg, oor_reg, written_reg};

endmodule

/* design/depth_tested_tile_blit.sv */
// Depth tested tile blit, top level: front end, item queue, back end with stores.
// Depends on dttb_pkg, dttb_front, dttb_queue and dttb_back.
//
// Input words on s_* carry one tile pixel with its tile origin and place in the
// tile (s_tuser low: composite) or a framebuffer read (s_tuser high). Every word
// gives one result word on m_*: written flag, out-of-range flag, read pixel.
// cfg_* writes the frame width (row stride), 512 after reset; write it idle only.
// After reset the block clears both stores, one pixel per cycle; s_tready stays
// low through that pass, cfg writes are taken throughout.
// From the accepting edge to m_tvalid a word passes the input register, the
// multiply by the width, the queue write (offset add and range check on the way
// in), and the back end's take item, read stores, and test and write.
// The back end handles one word at a time through its read, test and write
// sequence on the single port of the frame and depth memories, and takes no new
// word until it is through with the last.
// When m_tready is low the result holds, the back end waits, and the queue of 4
// and the front stages fill before s_tready drops.
module depth_tested_tile_blit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // origin_x, origin_y, col, row, pixel_in
    input  logic [dttb_pkg::S_DATA_W-1:0]   s_tdata,
    // op
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // written, out_of_range, pixel_out
    output logic [dttb_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dttb_pkg::WIDTH_W-1:0]    cfg_data
);
    import dttb_pkg::*;

    dttb_item_t        push_item, head_item;
    dttb_back_status_t back_status;
    logic              q_push, q_full, q_pop, q_empty;

    dttb_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .back_status (back_status),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    dttb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty)
    );

    dttb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_item (head_item),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .status    (back_status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.clearing |-> !s_tready)
        else $error("input accepted during store clear");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push)
        else $error("push into full queue");

    a_oor_not_written: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> !m_tdata[0] && m_tdata[33:2] == 32'd0)
        else $error("out of range result carries data");

    a_written_no_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[33:2] == 32'd0)
        else $error("composite result carries pixel");

endmodule

/* tb/tb_depth_tested_tile_blit.sv */
`timescale 1ns / 100ps
// Testbench for depth_tested_tile_blit: a directed table, then random composite and read words
// over several frame widths, checked against a framebuffer and depth store kept in the bench.
// Depends on dttb_pkg and the depth_tested_tile_blit RTL.
module tb_depth_tested_tile_blit;
    import dttb_pkg::*;

    localparam int IDLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_WORDS  = 88;
    localparam int STALL_CYCLES = 80;
    localparam int NUM_PHASES   = 6;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [TILE_W-1:0]  col;
        logic [TILE_W-1:0]  row;
        logic [PIXEL_W-1:0] pixel;
    } blit_word_t;

    typedef struct packed {
        logic               written;
        logic               out_of_range;
        logic [PIXEL_W-1:0] pixel_out;
    } blit_result_t;

    typedef struct packed {
        blit_word_t   word;
        logic         known;
        blit_result_t result;
    } blit_row_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [WIDTH_W-1:0]  cfg_data  = '0;

    bit [PIXEL_W-1:0]    frame_copy [FB_PIXELS];
    bit [DEPTH_W-1:0]    depth_copy [FB_PIXELS];
    logic [WIDTH_W-1:0]  stride_copy = WIDTH_RESET;

    blit_result_t        results_due [$];
    blit_row_t           directed_rows [$];
    int                  fail_count  = 0;
    int                  idle_cycles = 0;
    int                  s_idle_pct  = 0;
    int                  m_idle_pct  = 0;
    bit                  stall_armed = 1'b0;
    bit                  stall_taken = 1'b0;
    int                  stall_left  = 0;

    depth_tested_tile_blit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic blit_result_t blit_into_frame(input blit_word_t w);
        blit_result_t r;
        longint unsigned addr;
        r = '0;
        addr = (longint'(w.origin_y) + longint'(w.row)) * longint'(stride_copy)
               + longint'(w.origin_x) + longint'(w.col);
        if (addr >= FB_PIXELS) begin
            r.out_of_range = 1'b1;
        end else if (w.op == OP_READ) begin
            r.pixel_out = frame_copy[addr];
        end else if (w.pixel[31:24] != 8'h00 && depth_copy[addr] <= w.origin_y) begin
            frame_copy[addr] = {w.pixel[31:24], w.pixel[7:0], w.pixel[15:8], w.pixel[23:16]};
            depth_copy[addr] = w.origin_y;
            r.written = 1'b1;
        end
        return r;
    endfunction

    function automatic blit_word_t random_word();
        blit_word_t w;
        w.op = ($urandom_range(99) < 35) ? OP_READ : OP_BLIT;
        if ($urandom_range(99) < 15) begin
            w.origin_x = COORD_W'($urandom_range(4095));
            w.origin_y = COORD_W'($urandom_range(4095));
            w.col      = TILE_W'($urandom_range(511));
            w.row      = TILE_W'($urandom_range(511));
        end else begin
            // small tile window so words land on shared pixels and fight over depth
            w.origin_x = COORD_W'($urandom_range(7));
            w.origin_y = COORD_W'($urandom_range(15));
            w.col      = TILE_W'($urandom_range(7));
            w.row      = TILE_W'($urandom_range(3));
        end
        w.pixel = $urandom;
        if ($urandom_range(4) == 0)
            w.pixel[31:24] = 8'h00;
        return w;
    endfunction

    task automatic add_row(input logic op, input int ox, input int oy, input int col,
                           input int row, input logic [PIXEL_W-1:0] pixel, input int known,
                           input int written, input int oor,
                           input logic [PIXEL_W-1:0] pixel_out);
        blit_row_t r;
        r.word           = '{op, COORD_W'(ox), COORD_W'(oy), TILE_W'(col), TILE_W'(row), pixel};
        r.known          = known != 0;
        r.result         = '{written != 0, oor != 0, pixel_out};
        directed_rows    = {directed_rows, r};
    endtask

    task automatic push_word(input blit_word_t w, input logic known, input blit_result_t typed);
        blit_result_t r;
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.op;
        s_tdata  <= {6'b0, w.pixel, w.row, w.col, w.origin_y, w.origin_x};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        r = blit_into_frame(w);
        results_due = {results_due, (known ? typed : r)};
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_stride(input logic [WIDTH_W-1:0] stride);
        cfg_valid <= 1'b1;
        cfg_data  <= stride;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid   <= 1'b0;
        stride_copy  = stride;
    endtask

    always @(posedge aclk) begin
        blit_result_t got;
        blit_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.written      = m_tdata[0];
                got.out_of_range = m_tdata[1];
                got.pixel_out    = m_tdata[33:2];
                if (results_due.size() == 0) begin
                    $error("result word with nothing expected: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    if (got.written !== want.written) begin
                        $error("written: expected %0d, got %0d", want.written, got.written);
                        fail_count++;
                    end
                    if (got.out_of_range !== want.out_of_range) begin
                        $error("out_of_range: expected %0d, got %0d",
                               want.out_of_range, got.out_of_range);
                        fail_count++;
                    end
                    if (got.pixel_out !== want.pixel_out) begin
                        $error("pixel_out: expected %h, got %h", want.pixel_out, got.pixel_out);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (stall_armed && !stall_taken) begin
                stall_taken <= 1'b1;
                stall_left  <= STALL_CYCLES;
                m_tready    <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= m_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [WIDTH_W-1:0] strides [NUM_PHASES];
        strides = '{WIDTH_W'(1), WIDTH_W'(4096), WIDTH_W'(0), WIDTH_W'(8191),
                    WIDTH_W'(640), WIDTH_W'(512)};

        // frame width 512 after reset
        add_row(OP_READ, 0, 0, 0, 0, 32'h0, 1, 0, 0, 32'h0);
        add_row(OP_BLIT, 0, 0, 0, 0, 32'h80112233, 1, 1, 0, 32'h0);
        add_row(OP_READ, 0, 0, 0, 0, 32'h0, 1, 0, 0, 32'h80332211);
        add_row(OP_BLIT, 1, 0, 0, 0, 32'h00FFFFFF, 1, 0, 0, 32'h0);
        add_row(OP_READ, 0, 0, 1, 0, 32'h0, 1, 0, 0, 32'h0);
        add_row(OP_BLIT, 0, 5, 0, 0, 32'hFF0000FF, 0, 0, 0, 32'h0);
        add_row(OP_BLIT, 0, 4, 0, 1, 32'hFF00FF00, 0, 0, 0, 32'h0);
        add_row(OP_BLIT, 0, 5, 0, 0, 32'h01ABCDEF, 0, 0, 0, 32'h0);
        add_row(OP_READ, 0, 3, 0, 2, 32'h0, 0, 0, 0, 32'h0);
        add_row(OP_BLIT, 4095, 4095, 511, 511, 32'hFFFFFFFF, 1, 0, 1, 32'h0);
        add_row(OP_READ, 4095, 4095, 511, 511, 32'hFFFFFFFF, 1, 0, 1, 32'h0);
        add_row(OP_BLIT, 511, 511, 0, 0, 32'h7F0000FF, 1, 1, 0, 32'h0);
        add_row(OP_READ, 0, 510, 511, 1, 32'h0, 0, 0, 0, 32'h0);
        add_row(OP_BLIT, 0, 512, 0, 0, 32'hFFFFFFFF, 1, 0, 1, 32'h0);
        add_row(OP_READ, 0, 0, 0, 0, 32'hDEADBEEF, 0, 0, 0, 32'h0);
        add_row(OP_BLIT, 9, 3, 0, 0, 32'h10203040, 0, 0, 0, 32'h0);
        add_row(OP_BLIT, 0, 3, 9, 0, 32'h50607080, 0, 0, 0, 32'h0);
        add_row(OP_READ, 9, 3, 0, 0, 32'h0, 0, 0, 0, 32'h0);
        add_row(OP_BLIT, 9, 2, 0, 1, 32'hAA000000, 0, 0, 0, 32'h0);
        add_row(OP_READ, 0, 0, 9, 3, 32'h0, 0, 0, 0, 32'h0);

        s_idle_pct = 21;
        m_idle_pct = 86;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            push_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].result);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_pipeline();
            write_stride(strides[phase]);
            if (phase == 2) begin
                s_idle_pct = 86;
                m_idle_pct = 21;
            end
            if (phase == 4) begin
                s_idle_pct  = 0;
                m_idle_pct  = 0;
                stall_armed = 1'b1;
            end
            for (int n = 0; n < PHASE_WORDS; n++)
                push_word(random_word(), 1'b0, '0);
        end
        drain_pipeline();

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
design/dttb_pkg.sv
design/dttb_front.sv
design/dttb_queue.sv
design/dttb_back.sv
design/depth_tested_tile_blit.sv
tb/tb_depth_tested_tile_blit.sv
